@@ hdl/pcic_pkg.sv @@
package pcic_pkg;

  localparam int WORD_BITS = 32;
  localparam int IDX_W = (WORD_BITS > 2) ? $clog2(WORD_BITS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WORD_BITS - 1);
  localparam logic [IDX_W-1:0] HALF_IDX = IDX_W'(WORD_BITS / 2);

  localparam int INT_W = 32;
  localparam int D1_W = INT_W + 1;
  localparam int D2_W = INT_W + 2;
  localparam int WRAP_W = INT_W + 3;
  localparam int PCM_W = 16;

  localparam logic signed [WRAP_W-1:0] WRAP_HIGH = WRAP_W'(64'sd1073741823);
  localparam logic signed [WRAP_W-1:0] WRAP_LOW = WRAP_W'(-64'sd1073741824);

  localparam int INQ_DEPTH = 2;
  localparam int INQ_PTR_W = 1;
  localparam int INQ_CNT_W = $clog2(INQ_DEPTH + 1);

  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);
  localparam int OUTQ_RESERVE = 3;

  typedef struct packed {
    logic valid;
    logic last;
    logic signed [INT_W-1:0] value;
  } tap_t;

  typedef struct packed {
    logic last;
    logic signed [PCM_W-1:0] pcm;
  } res_t;

  function automatic logic signed [WRAP_W-1:0] wrap30(input logic signed [WRAP_W-1:0] v);
    logic signed [WRAP_W-1:0] t;
    t = v;
    if (t >= WRAP_HIGH) t = t - WRAP_HIGH;
    if (t <= WRAP_LOW) t = t - WRAP_LOW;
    return t;
  endfunction

endpackage

@@ hdl/pcic_front.sv @@
module pcic_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            push,
  output logic                            full,
  input  logic [pcic_pkg::WORD_BITS-1:0]  pdm_word,
  output logic                            q_valid,
  output logic [pcic_pkg::WORD_BITS-1:0]  q_word,
  input  logic                            q_pop
);

  logic [pcic_pkg::WORD_BITS-1:0] slots [pcic_pkg::INQ_DEPTH];
  logic [pcic_pkg::INQ_PTR_W-1:0] wr_ptr;
  logic [pcic_pkg::INQ_PTR_W-1:0] rd_ptr;
  logic [pcic_pkg::INQ_CNT_W-1:0] count;
  logic                           do_push;
  logic                           do_pop;

  assign full    = (count == pcic_pkg::INQ_CNT_W'(pcic_pkg::INQ_DEPTH));
  assign q_valid = (count != '0);
  assign q_word  = slots[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        slots[wr_ptr] <= pdm_word;
        wr_ptr        <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hdl/pcic_integ.sv @@
module pcic_integ (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            q_valid,
  input  logic [pcic_pkg::WORD_BITS-1:0]  q_word,
  output logic                            q_pop,
  input  logic                            start_ok,
  output pcic_pkg::tap_t                  tap
);

  logic                                   busy;
  logic [pcic_pkg::IDX_W-1:0]             idx;
  logic [pcic_pkg::WORD_BITS-1:0]         word_sr;
  logic signed [pcic_pkg::INT_W-1:0]      i1;
  logic signed [pcic_pkg::INT_W-1:0]      i2;
  logic signed [pcic_pkg::INT_W-1:0]      i1_next;
  logic signed [pcic_pkg::INT_W-1:0]      i2_next;
  logic signed [pcic_pkg::WRAP_W-1:0]     step;
  logic signed [pcic_pkg::WRAP_W-1:0]     w1;
  logic signed [pcic_pkg::WRAP_W-1:0]     w2;
  logic                                   at_last;
  logic                                   load;
  logic                                   tap_hit;

  always_comb begin
    step    = word_sr[pcic_pkg::WORD_BITS-1] ? pcic_pkg::WRAP_W'(1) : '1;
    w1      = pcic_pkg::wrap30(pcic_pkg::WRAP_W'(i1) + step);
    i1_next = w1[pcic_pkg::INT_W-1:0];
    w2      = pcic_pkg::wrap30(pcic_pkg::WRAP_W'(i2) + pcic_pkg::WRAP_W'(i1_next));
    i2_next = w2[pcic_pkg::INT_W-1:0];
    at_last = busy && (idx == pcic_pkg::LAST_IDX);
    tap_hit = busy && (idx == '0 || idx == pcic_pkg::HALF_IDX);
    load    = q_valid && start_ok && (!busy || at_last);
    q_pop   = load;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
      i1   <= '0;
      i2   <= '0;
      tap  <= '0;
    end else begin
      tap.valid <= tap_hit;
      if (tap_hit) begin
        tap.last  <= (idx == pcic_pkg::HALF_IDX);
        tap.value <= i2_next;
      end
      if (busy) begin
        i1 <= i1_next;
        i2 <= i2_next;
      end
      if (load) begin
        busy    <= 1'b1;
        idx     <= '0;
        word_sr <= q_word;
      end else if (busy) begin
        busy    <= !at_last;
        idx     <= idx + 1'b1;
        word_sr <= {word_sr[pcic_pkg::WORD_BITS-2:0], 1'b0};
      end
    end
  end

endmodule

@@ hdl/pcic_comb.sv @@
module pcic_comb (
  input  logic                                clk,
  input  logic                                rst,
  input  pcic_pkg::tap_t                      tap,
  output logic                                start_ok,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [pcic_pkg::PCM_W-1:0]   pcm_value,
  output logic                                last_of_word
);

  logic signed [pcic_pkg::INT_W-1:0]     c1;
  logic signed [pcic_pkg::D1_W-1:0]      c2;
  logic signed [pcic_pkg::D1_W-1:0]      d1;
  logic signed [pcic_pkg::D2_W-1:0]      d2;
  logic signed [pcic_pkg::WRAP_W-1:0]    wrapped;
  logic                                  va;
  logic                                  la;
  logic                                  vb;
  logic                                  lb;

  pcic_pkg::res_t                        slots [pcic_pkg::OUTQ_DEPTH];
  logic [pcic_pkg::OUTQ_PTR_W-1:0]       wr_ptr;
  logic [pcic_pkg::OUTQ_PTR_W-1:0]       rd_ptr;
  logic [pcic_pkg::OUTQ_CNT_W-1:0]       count;
  logic [pcic_pkg::OUTQ_CNT_W:0]         used;
  logic                                  do_pop;

  always_comb begin
    wrapped  = pcic_pkg::wrap30(pcic_pkg::WRAP_W'(d2));
    used     = (pcic_pkg::OUTQ_CNT_W+1)'(count) + (pcic_pkg::OUTQ_CNT_W+1)'(tap.valid)
             + (pcic_pkg::OUTQ_CNT_W+1)'(va) + (pcic_pkg::OUTQ_CNT_W+1)'(vb);
    start_ok = (used <= (pcic_pkg::OUTQ_CNT_W+1)'(pcic_pkg::OUTQ_DEPTH - pcic_pkg::OUTQ_RESERVE));
    empty    = (count == '0);
    do_pop   = pop && !empty;
    pcm_value    = slots[rd_ptr].pcm;
    last_of_word = slots[rd_ptr].last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      c1     <= '0;
      c2     <= '0;
      va     <= 1'b0;
      vb     <= 1'b0;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      va <= tap.valid;
      vb <= va;
      if (tap.valid) begin
        d1 <= pcic_pkg::D1_W'(tap.value) - pcic_pkg::D1_W'(c1);
        la <= tap.last;
        c1 <= tap.value;
      end
      if (va) begin
        d2 <= pcic_pkg::D2_W'(d1) - pcic_pkg::D2_W'(c2);
        lb <= la;
        c2 <= d1;
      end
      if (vb) begin
        slots[wr_ptr] <= '{last: lb, pcm: wrapped[pcic_pkg::PCM_W-1:0]};
        wr_ptr        <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({vb, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ hdl/pdm_cic2_decimator_top.sv @@
// Each result passes the tap register, comb registers d1 and d2 and the output
// queue; a word is tapped at its first and middle bits. The integrator pair
// handles one PDM bit per cycle and can start the next word on the last bit of
// the current one. A 2-entry input queue takes words while a word is integrating.
// Reset (rst, synchronous): integrators, comb delays and both queues cleared.
module pdm_cic2_decimator_top (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                push,
  output logic                                full,
  input  logic [pcic_pkg::WORD_BITS-1:0]      pdm_word,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [pcic_pkg::PCM_W-1:0]   pcm_value,
  output logic                                last_of_word
);

  logic                           q_valid;
  logic [pcic_pkg::WORD_BITS-1:0] q_word;
  logic                           q_pop;
  logic                           start_ok;
  pcic_pkg::tap_t                 tap;

  pcic_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .pdm_word (pdm_word),
    .q_valid  (q_valid),
    .q_word   (q_word),
    .q_pop    (q_pop)
  );

  pcic_integ u_integ (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_word   (q_word),
    .q_pop    (q_pop),
    .start_ok (start_ok),
    .tap      (tap)
  );

  pcic_comb u_comb (
    .clk          (clk),
    .rst          (rst),
    .tap          (tap),
    .start_ok     (start_ok),
    .empty        (empty),
    .pop          (pop),
    .pcm_value    (pcm_value),
    .last_of_word (last_of_word)
  );

`ifndef SYNTHESIS
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) q_pop |-> q_valid)
    else $error("integrator took a word from an empty queue");
  a_pop_room: assert property (@(posedge clk) disable iff (rst) q_pop |-> start_ok)
    else $error("word started without result room");
  a_first_tap: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> ##1 (tap.valid && !tap.last))
    else $error("first tap of a word missing");
`endif

endmodule
